// ===== rtl/websocket_frame_unmasker_top_assert.svh =====
// Assertion macros shared by the frame unmasker modules
`ifndef WEBSOCKET_FRAME_UNMASKER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define WSU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame unmasker assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define WSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame unmasker assertion failed");

`endif

// ===== rtl/wsu_pkg.sv =====
// Types and constants shared by the frame unmasker modules
`timescale 1ns / 1ps
package wsu_pkg;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;
	localparam int STATUS_W  = 3;
	localparam int LEN_W     = 16;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_EXT  = 3'd1,
		PH_KEY  = 3'd2,
		PH_DATA = 3'd3
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BYTE     = 3'd0,
		ST_BADFLAGS = 3'd1,
		ST_LEN64    = 3'd2,
		ST_TOOLONG  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	localparam logic FUNC_HEADER = 1'b0;
	localparam logic FUNC_BYTE   = 1'b1;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 16'd256;
	localparam logic [6:0]       LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0]       LEN_CODE_EXT64 = 7'd127;
	localparam logic [2:0]       EXT_LEN_BYTES  = 3'd2;
	localparam logic [2:0]       KEY_BYTES      = 3'd4;

	typedef struct packed {
		logic       func;
		logic       fin_bit;
		logic       mask_bit;
		logic [6:0] base_length;
		logic [7:0] frame_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		status_t    status;
		logic       last;
	} result_t;

endpackage

// ===== rtl/wsu_parser.sv =====
// Frame parser: header checks, length and key capture, payload unmasking
`timescale 1ns / 1ps
`include "websocket_frame_unmasker_top_assert.svh"
module wsu_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [wsu_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                      adv,
	input  wsu_pkg::item_t            item,
	output logic                      res_valid,
	output wsu_pkg::result_t          res
);
	import wsu_pkg::*;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   ext_len_q, ext_len_d;
	logic [31:0]        key_q, key_d;
	logic [2:0]         hbc_q, hbc_d;
	logic [LEN_W-1:0]   rem_q, rem_d;
	logic [1:0]         kidx_q, kidx_d;
	logic [LEN_W-1:0]   max_len_q;
	logic               len_known;
	logic [LEN_W-1:0]   len_val;
	logic [7:0]         key_byte;

	always_comb begin
		case (kidx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d          = phase_q;
		ext_len_d        = ext_len_q;
		key_d            = key_q;
		hbc_d            = hbc_q;
		rem_d            = rem_q;
		kidx_d           = kidx_q;
		res_valid        = 1'b0;
		res.payload_byte = 8'd0;
		res.status       = ST_BYTE;
		res.last         = 1'b0;
		len_known        = 1'b0;
		len_val          = '0;

		if (item.func == FUNC_HEADER) begin
			// a header abandons any frame in progress
			hbc_d  = 3'd0;
			kidx_d = 2'd0;
			rem_d  = '0;
			if (!item.mask_bit || !item.fin_bit) begin
				phase_d    = PH_IDLE;
				res_valid  = 1'b1;
				res.status = ST_BADFLAGS;
				res.last   = 1'b1;
			end else if (item.base_length == LEN_CODE_EXT64) begin
				phase_d    = PH_IDLE;
				res_valid  = 1'b1;
				res.status = ST_LEN64;
				res.last   = 1'b1;
			end else if (item.base_length == LEN_CODE_EXT16) begin
				ext_len_d = '0;
				phase_d   = PH_EXT;
			end else begin
				len_known = 1'b1;
				len_val   = {{(LEN_W-7){1'b0}}, item.base_length};
			end
		end else begin
			case (phase_q)
				PH_EXT: begin
					ext_len_d = {ext_len_q[7:0], item.frame_byte};
					hbc_d     = hbc_q + 3'd1;
					if (hbc_d >= EXT_LEN_BYTES) begin
						len_known = 1'b1;
						len_val   = ext_len_d;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], item.frame_byte};
					hbc_d = hbc_q + 3'd1;
					if (hbc_d >= KEY_BYTES) begin
						kidx_d  = 2'd0;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					kidx_d           = kidx_q + 2'd1;
					rem_d            = rem_q - 16'd1;
					res_valid        = 1'b1;
					res.payload_byte = item.frame_byte ^ key_byte;
					res.last         = (rem_d == '0);
					if (rem_d == '0) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					// drop bytes while idle
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (len_known) begin
			if (len_val > max_len_q) begin
				phase_d    = PH_IDLE;
				res_valid  = 1'b1;
				res.status = ST_TOOLONG;
				res.last   = 1'b1;
			end else if (len_val == '0) begin
				phase_d    = PH_IDLE;
				res_valid  = 1'b1;
				res.status = ST_EMPTY;
				res.last   = 1'b1;
			end else begin
				rem_d   = len_val;
				hbc_d   = 3'd0;
				key_d   = '0;
				phase_d = PH_KEY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			ext_len_q <= '0;
			key_q     <= '0;
			hbc_q     <= 3'd0;
			rem_q     <= '0;
			kidx_q    <= 2'd0;
		end else if (adv) begin
			phase_q   <= phase_d;
			ext_len_q <= ext_len_d;
			key_q     <= key_d;
			hbc_q     <= hbc_d;
			rem_q     <= rem_d;
			kidx_q    <= kidx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	`WSU_ASSERT_NOW(a_data_has_bytes_left, phase_q == PH_DATA, rem_q != '0)
	`WSU_ASSERT_NOW(a_ext_count_range, phase_q == PH_EXT, hbc_q < EXT_LEN_BYTES)
	`WSU_ASSERT_NEXT(a_bad_flags_go_idle, adv && item.func == FUNC_HEADER && !item.mask_bit, phase_q == PH_IDLE)

endmodule

// ===== rtl/wsu_obuf.sv =====
// Result register between the parser and the output stream
`timescale 1ns / 1ps
module wsu_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             res_valid,
	input  wsu_pkg::result_t res,
	input  logic             out_ready,
	output logic             out_valid,
	output wsu_pkg::result_t out_res,
	output logic             free
);
	import wsu_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	// the slot frees up in the same cycle as the held item is taken
	assign free      = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== rtl/websocket_frame_unmasker_top.sv =====
// An accepted item passes through the input register and the parser into the result register, which drives the output.
// Throughput: one item per cycle; the input register hands on an item whenever the
// result register is empty or being taken, so a stall only holds on downstream tready.
// Items that cause no result (key, extended length, idle bytes) still pass through the input register and parser.
// Reset (arst_n low, asynchronous): both stages empty, parser idle, length limit 256.
// Top level of the frame unmasker: input register, parser, result register
`timescale 1ns / 1ps
`include "websocket_frame_unmasker_top_assert.svh"
module websocket_frame_unmasker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wsu_pkg::LEN_W-1:0]     cfg_wdata,    // max_payload_length
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// fin_bit [0], mask_bit [1], base_length [8:2], frame_byte [16:9], zero [23:17]
	input  logic [wsu_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  logic                          s_axis_tuser, // func
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [wsu_pkg::M_TDATA_W-1:0] m_axis_tdata, // payload_byte [7:0]
	output logic [wsu_pkg::STATUS_W-1:0]  m_axis_tuser, // status [2:0]
	output logic                          m_axis_tlast  // last
);
	import wsu_pkg::*;

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	logic    free;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign item_in.func        = s_axis_tuser;
	assign item_in.fin_bit     = s_axis_tdata[0];
	assign item_in.mask_bit    = s_axis_tdata[1];
	assign item_in.base_length = s_axis_tdata[8:2];
	assign item_in.frame_byte  = s_axis_tdata[16:9];

	assign adv           = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	wsu_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsu_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.free      (free)
	);

	assign m_axis_tdata = out_res.payload_byte;
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last;

	`WSU_ASSERT_NOW(a_status_is_last, m_axis_tvalid && m_axis_tuser != ST_BYTE, m_axis_tlast)
	`WSU_ASSERT_NOW(a_reject_has_no_byte, m_axis_tvalid && m_axis_tuser != ST_BYTE, m_axis_tdata == '0)

endmodule
